// ===== rtl/modulo_hash_table_engine_assert.svh =====
// Assertion macros for the hash table engine
`ifndef MODULO_HASH_TABLE_ENGINE_ASSERT_SVH
`define MODULO_HASH_TABLE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define MHT_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define MHT_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define MHT_ASSERT_IMPL(label, clk, rst_n, a, c, msg)
`define MHT_ASSERT_NEXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// ===== rtl/mht_pkg.sv =====
`default_nettype none
package mht_pkg;
    localparam int NUM_BUCKETS = 64;
    localparam int WAYS        = 4;
    localparam int KEY_WIDTH   = 50;
    localparam int DATA_WIDTH  = 32;
    localparam int BKT_W       = $clog2(NUM_BUCKETS);
    localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOT_W      = $clog2(NUM_BUCKETS * WAYS);
    localparam int CNT_W       = 9;
    localparam int DIV_W       = BKT_W + 1;
    localparam int KEYBIT_W    = $clog2(KEY_WIDTH + 1);

    typedef logic [1:0] t_req;
    localparam t_req REQ_INSERT = 2'd0;
    localparam t_req REQ_LOOKUP = 2'd1;
    localparam t_req REQ_DELETE = 2'd2;
    localparam t_req REQ_CLEAR  = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_NOTFOUND = 2'd1;
    localparam t_status ST_FULL     = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_VRD, S_VCHK, S_PROBE, S_DONE, S_CLR, S_INIT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [KEY_WIDTH-1:0] key;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [BKT_W-1:0] rem;
    } t_div_rsp;
endpackage
`default_nettype wire

// ===== rtl/modulo_hash_table_engine.sv =====
`default_nettype none
// Channel   | Direction | Signals
// request   | in        | i_start/o_busy, i_req_type, i_key, i_entry_data
// result    | out       | o_done strobe, o_status, o_found_data, o_entry_count
// config    | in        | i_cfg_we, i_cfg_wdata (bucket_count)
//
// After an accept, mht_mod runs its 50 remainder steps, then the bucket is
// captured and the valid row is read (S_VRD) and checked (S_VCHK); insert then
// ends in S_DONE, lookup/delete probe the ways in S_PROBE to a hit or the last way.
// o_busy stays high through the o_done beat and drops after it.
// Clear runs a zeroing pass over every bucket row of the valid memory, then beats o_done.
// Sync active-low reset starts the same zeroing pass with o_busy high;
// the receiver cannot stall.
module modulo_hash_table_engine (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    output logic                                 o_busy,
    input  wire logic [1:0]                      i_req_type,
    input  wire logic [mht_pkg::KEY_WIDTH-1:0]   i_key,
    input  wire logic [mht_pkg::DATA_WIDTH-1:0]  i_entry_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [6:0]                      i_cfg_wdata,
    output logic                                 o_done,
    output logic [1:0]                           o_status,
    output logic [mht_pkg::DATA_WIDTH-1:0]       o_found_data,
    output logic [mht_pkg::CNT_W-1:0]            o_entry_count
);
    import mht_pkg::*;
    `include "modulo_hash_table_engine_assert.svh"

    t_state r_state, n_state;
    logic [6:0]            r_bcount;
    t_req                  r_req;
    logic [KEY_WIDTH-1:0]  r_key;
    logic [DATA_WIDTH-1:0] r_data;
    logic [BKT_W-1:0]      r_bkt;
    logic [BKT_W-1:0]      r_clr, n_clr;
    logic [WAY_W:0]        r_way, n_way;
    logic [CNT_W-1:0]      r_count;
    logic [1:0]            r_status;
    logic [DATA_WIDTH-1:0] r_found;
    logic                  r_done;

    t_div_req div_req;
    t_div_rsp div_rsp;
    logic [DIV_W-1:0] divisor;

    // Divisor: zero maps to one, saturates at the bucket total.
    always_comb begin
        if (r_bcount == '0) divisor = DIV_W'(1);
        else if ({1'b0, r_bcount} > 8'(NUM_BUCKETS)) divisor = DIV_W'(NUM_BUCKETS);
        else divisor = DIV_W'(r_bcount);
    end

    logic accept;
    assign accept = i_start && !o_busy;

    assign div_req.start   = accept && (i_req_type != REQ_CLEAR);
    assign div_req.key     = i_key;
    assign div_req.divisor = divisor;

    mht_mod u_mod (
        .i_clk (i_clk),
        .i_rst_n (i_rst_n),
        .i_req (div_req),
        .o_rsp (div_rsp)
    );

    // Slot memory holds key and payload, one row of WAYS slots per bucket.
    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_waddr, mem_raddr;
    logic [KEY_WIDTH+DATA_WIDTH-1:0] slot_rd;
    logic [KEY_WIDTH-1:0]  key_rd;
    logic [DATA_WIDTH-1:0] data_rd;
    logic [WAY_W-1:0]      way_idx;
    logic [WAY_W-1:0]      free_way;
    logic                  has_free;

    // Valid memory: one WAYS-bit row per bucket, read at r_bkt.
    logic                  valid_we;
    logic [BKT_W-1:0]      valid_waddr;
    logic [WAYS-1:0]       valid_wdata;
    logic [WAYS-1:0]       valid_rd;
    logic                  clr_last;

    assign way_idx   = r_way[WAY_W-1:0];
    assign mem_raddr = SLOT_W'({r_bkt, way_idx});
    assign mem_waddr = SLOT_W'({r_bkt, free_way});
    assign key_rd    = slot_rd[KEY_WIDTH+DATA_WIDTH-1:DATA_WIDTH];
    assign data_rd   = slot_rd[DATA_WIDTH-1:0];
    assign clr_last  = (r_clr == BKT_W'(NUM_BUCKETS - 1));

    mht_ram #(.WIDTH(KEY_WIDTH + DATA_WIDTH), .DEPTH(NUM_BUCKETS * WAYS)) u_slot_ram (
        .i_clk (i_clk), .i_we (mem_we), .i_waddr (mem_waddr),
        .i_wdata ({r_key, r_data}), .i_raddr (mem_raddr), .o_rdata (slot_rd)
    );
    mht_ram #(.WIDTH(WAYS), .DEPTH(NUM_BUCKETS)) u_valid_ram (
        .i_clk (i_clk), .i_we (valid_we), .i_waddr (valid_waddr),
        .i_wdata (valid_wdata), .i_raddr (r_bkt), .o_rdata (valid_rd)
    );

    // Lowest free way in the fetched row.
    always_comb begin
        free_way = '0;
        has_free = 1'b0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!valid_rd[w]) begin
                free_way = WAY_W'(w);
                has_free = 1'b1;
            end
        end
    end

    // Probe pipeline: address way r_way issued, data arrives next cycle for
    // way r_way-1. A hit is on the previous way.
    logic [WAY_W:0]   prev_way;
    logic             prev_ok;
    logic             hit;
    assign prev_way = r_way - 1'b1;
    assign prev_ok  = (r_way != '0);
    assign hit = prev_ok && valid_rd[prev_way[WAY_W-1:0]] && (key_rd == r_key);

    logic probe_end;
    assign probe_end = hit || (r_way == (WAY_W+1)'(WAYS));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = (i_req_type == REQ_CLEAR) ? S_CLR : S_DIV;
            S_DIV:  if (div_rsp.done) n_state = S_VRD;
            S_VRD:  n_state = S_VCHK;
            S_VCHK: n_state = (r_req == REQ_INSERT) ? S_DONE : S_PROBE;
            S_PROBE: if (probe_end) n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            S_CLR:  if (clr_last) n_state = S_IDLE;
            S_INIT: if (clr_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mem_we      = (r_state == S_VCHK) && (r_req == REQ_INSERT) && has_free;
        n_way       = r_way;
        n_clr       = '0;
        valid_we    = 1'b0;
        valid_waddr = r_bkt;
        valid_wdata = valid_rd;
        case (r_state)
            S_VCHK: begin
                n_way = (WAY_W+1)'(1);
                if (r_req == REQ_INSERT && has_free) begin
                    valid_we    = 1'b1;
                    valid_wdata = valid_rd | (WAYS'(1) << free_way);
                end
            end
            S_PROBE: begin
                n_way = probe_end ? r_way : r_way + 1'b1;
                if (hit && r_req != REQ_LOOKUP) begin
                    valid_we    = 1'b1;
                    valid_wdata = valid_rd & ~(WAYS'(1) << prev_way[WAY_W-1:0]);
                end
            end
            S_CLR, S_INIT: begin
                n_way       = '0;
                n_clr       = clr_last ? '0 : r_clr + 1'b1;
                valid_we    = 1'b1;
                valid_waddr = r_clr;
                valid_wdata = '0;
            end
            default: n_way = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_bcount <= 7'd61;
            r_count  <= '0;
            r_done   <= 1'b0;
            r_way    <= '0;
            r_clr    <= '0;
        end else begin
            r_state <= n_state;
            r_way   <= n_way;
            r_clr   <= n_clr;
            r_done  <= 1'b0;
            if (i_cfg_we) r_bcount <= i_cfg_wdata;
            case (r_state)
                S_VCHK: begin
                    if (r_req == REQ_INSERT) begin
                        if (has_free) begin
                            r_count  <= r_count + 1'b1;
                            r_status <= ST_OK;
                        end else begin
                            r_status <= ST_FULL;
                        end
                    end
                end
                S_PROBE: begin
                    if (hit) begin
                        r_status <= ST_OK;
                        if (r_req == REQ_LOOKUP) r_found <= data_rd;
                        else begin
                            if (r_count != '0) r_count <= r_count - 1'b1;
                        end
                    end else if (probe_end) begin
                        r_status <= ST_NOTFOUND;
                    end
                end
                S_DONE: r_done <= 1'b1;
                S_CLR: begin
                    r_count  <= '0;
                    r_status <= ST_OK;
                    r_done   <= clr_last;
                end
                default: ;
            endcase
        end
        if (accept) begin
            r_req   <= i_req_type;
            r_key   <= i_key;
            r_data  <= i_entry_data;
            r_found <= '0;
        end
        if (div_rsp.done) r_bkt <= div_rsp.rem;
    end

    assign o_busy        = (r_state != S_IDLE) || r_done;
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found_data  = r_found;
    assign o_entry_count = r_count;

    `MHT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, o_busy, "busy not raised")
    `MHT_ASSERT_IMPL(a_done_status, i_clk, i_rst_n, o_done,
        o_status == ST_OK || o_status == ST_NOTFOUND || o_status == ST_FULL, "bad status")
    `MHT_ASSERT_NEXT(a_clear_zero, i_clk, i_rst_n, r_state == S_CLR, o_entry_count == '0,
        "count not cleared")
    `MHT_ASSERT_IMPL(a_found_zero, i_clk, i_rst_n, o_done && o_status != ST_OK,
        o_found_data == '0, "data on miss")
endmodule
`default_nettype wire

// ===== rtl/mht_ram.sv =====
`default_nettype none
module mht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/mht_mod.sv =====
`default_nettype none
// Restoring remainder, one key bit per cycle, MSB first.
module mht_mod (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mht_pkg::t_div_req i_req,
    output mht_pkg::t_div_rsp   o_rsp
);
    import mht_pkg::*;

    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [DIV_W-1:0]     r_rem, n_rem;
    logic [DIV_W-1:0]     r_div, n_div;
    logic [KEYBIT_W-1:0]  r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_W:0]       shifted;
    logic [DIV_W:0]       diff;

    always_comb begin
        shifted = {r_rem, r_key[KEY_WIDTH-1]};
        diff    = shifted - {1'b0, r_div};
        n_key   = r_key;
        n_rem   = r_rem;
        n_div   = r_div;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_key  = i_req.key;
            n_div  = i_req.divisor;
            n_rem  = '0;
            n_cnt  = KEYBIT_W'(KEY_WIDTH);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_key = {r_key[KEY_WIDTH-2:0], 1'b0};
            n_rem = diff[DIV_W] ? shifted[DIV_W-1:0] : diff[DIV_W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == KEYBIT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_key <= n_key;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem[BKT_W-1:0];
endmodule
`default_nettype wire
